// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the signature dedup table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/sdt_pkg.sv =====
// Package: constants and payload types of the signature dedup table.
`timescale 1ns / 1ps
`default_nettype none
package sdt_pkg;

  localparam int ENTRIES_C    = 32;
  localparam int MAX_PARAMS_C = 8;
  localparam int ID_BITS_C    = 22;

  localparam int FIELD_W = 22;
  localparam int CNT_W   = 4;

  typedef struct packed {
    logic               is_entry;
    logic [FIELD_W-1:0] ret_id;
    logic [CNT_W-1:0]   param_count;
    logic [FIELD_W-1:0] param0;
    logic [FIELD_W-1:0] param1;
    logic [FIELD_W-1:0] param2;
    logic [FIELD_W-1:0] param3;
    logic [FIELD_W-1:0] param4;
    logic [FIELD_W-1:0] param5;
    logic [FIELD_W-1:0] param6;
    logic [FIELD_W-1:0] param7;
  } sdt_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] type_id;
    logic               emit_decl;
    logic               not_stored;
    logic               id_exhausted;
  } sdt_out_t;

  typedef struct packed {
    logic shift;
    logic occupied;
  } sdt_cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_RES  = 3'b100
  } sdt_state_t;

endpackage
`default_nettype wire

// ===== rtl/sdt_cell.sv =====
// One table cell: holds one stored signature, compares it, shifts it on insert.
`timescale 1ns / 1ps
`default_nettype none
module sdt_cell
  import sdt_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_C,
  parameter int ID_BITS    = ID_BITS_C
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sdt_cell_ctrl_t                        ctrl,
  input  logic [FIELD_W-1:0]                    q_ret,
  input  logic [CNT_W-1:0]                      q_cnt,
  input  logic [MAX_PARAMS-1:0][FIELD_W-1:0]    q_par,
  input  logic [FIELD_W-1:0]                    prev_ret,
  input  logic [CNT_W-1:0]                      prev_cnt,
  input  logic [MAX_PARAMS-1:0][FIELD_W-1:0]    prev_par,
  input  logic [ID_BITS-1:0]                    prev_id,
  output logic [FIELD_W-1:0]                    ent_ret,
  output logic [CNT_W-1:0]                      ent_cnt,
  output logic [MAX_PARAMS-1:0][FIELD_W-1:0]    ent_par,
  output logic [ID_BITS-1:0]                    ent_id,
  output logic                                  hit,
  output logic [ID_BITS-1:0]                    hit_id
);

  logic [FIELD_W-1:0]                 ret_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [MAX_PARAMS-1:0][FIELD_W-1:0] par_r;
  logic [ID_BITS-1:0]                 id_r;
  logic                               hit_r;
  logic [ID_BITS-1:0]                 hit_id_r;
  logic [MAX_PARAMS-1:0]              par_ok;
  logic                               match;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      ret_r <= prev_ret;
      cnt_r <= prev_cnt;
      par_r <= prev_par;
      id_r  <= prev_id;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_PARAMS; j++) begin
      par_ok[j] = (CNT_W'(j) >= cnt_r) || (par_r[j] == q_par[j]);
    end
    match = ctrl.occupied && (ret_r == q_ret) && (cnt_r == q_cnt) && (&par_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= match;
    end
  end

  always_ff @(posedge clk) begin
    hit_id_r <= match ? id_r : '0;
  end

  assign ent_ret = ret_r;
  assign ent_cnt = cnt_r;
  assign ent_par = par_r;
  assign ent_id  = id_r;
  assign hit     = hit_r;
  assign hit_id  = hit_id_r;

endmodule
`default_nettype wire

// ===== rtl/signature_dedup_table_top.sv =====
// Top level of the signature dedup table: control, id counter and the cell row.
// The table is a row of ENTRIES cells; a new signature enters cell 0 and every
// occupied cell hands its contents to the next one. Each request passes through
// a compare cycle in which all cells compare against the request in parallel
// and register their hit, and a resolve cycle that merges the hits, assigns an
// id, inserts the signature and loads the output register; the next request is
// taken at the end of that resolve cycle. A stalled result holds the block in
// the resolve cycle. A write of the start id (0 loads 1) is taken only while
// idle, empties the table at once and restarts the id counter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module signature_dedup_table_top
  import sdt_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_C,
  parameter int MAX_PARAMS = MAX_PARAMS_C,
  parameter int ID_BITS    = ID_BITS_C
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdt_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sdt_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data
);

  localparam int FILL_W = $clog2(ENTRIES + 1);

  sdt_state_t         st_r, st_nxt;
  sdt_in_t            q_r, q_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  sdt_out_t           out_data_r, out_data_nxt;

  logic               in_acc, cfg_acc, out_free, res_go;
  logic [CNT_W-1:0]   q_cnt;
  logic [7:0][FIELD_W-1:0]             all_par;
  logic [MAX_PARAMS-1:0][FIELD_W-1:0] q_par;

  logic [ENTRIES-1:0][FIELD_W-1:0]                  c_ret;
  logic [ENTRIES-1:0][CNT_W-1:0]                    c_cnt;
  logic [ENTRIES-1:0][MAX_PARAMS-1:0][FIELD_W-1:0]  c_par;
  logic [ENTRIES-1:0][ID_BITS-1:0]                  c_id;
  logic [ENTRIES-1:0]                               c_hit;
  logic [ENTRIES-1:0][ID_BITS-1:0]                  c_hit_id;

  logic               found, exhausted, can_store, do_store;
  logic [ID_BITS-1:0] found_id, res_id;
  logic [ID_BITS+FIELD_W-1:0] cfg_wide, id_wide;
  logic [ID_BITS-1:0] cfg_id;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((st_r == ST_IDLE) || ((st_r == ST_RES) && out_free));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (st_r == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign res_go    = (st_r == ST_RES) && out_free;

  assign all_par = {q_r.param7, q_r.param6, q_r.param5, q_r.param4,
                    q_r.param3, q_r.param2, q_r.param1, q_r.param0};
  assign q_cnt   = q_r.param_count;

  genvar g;
  generate
    for (g = 0; g < MAX_PARAMS; g++) begin : g_qpar
      assign q_par[g] = all_par[g];
    end

    for (g = 0; g < ENTRIES; g++) begin : g_cell
      sdt_cell_ctrl_t ctrl;
      assign ctrl = '{shift: do_store, occupied: (FILL_W'(g) < fill_r)};
      if (g == 0) begin : g_head
        sdt_cell #(.MAX_PARAMS(MAX_PARAMS), .ID_BITS(ID_BITS)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
          .q_ret(q_r.ret_id), .q_cnt(q_cnt), .q_par(q_par),
          .prev_ret(q_r.ret_id), .prev_cnt(q_cnt), .prev_par(q_par),
          .prev_id(res_id),
          .ent_ret(c_ret[g]), .ent_cnt(c_cnt[g]), .ent_par(c_par[g]),
          .ent_id(c_id[g]), .hit(c_hit[g]), .hit_id(c_hit_id[g])
        );
      end else begin : g_body
        sdt_cell #(.MAX_PARAMS(MAX_PARAMS), .ID_BITS(ID_BITS)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
          .q_ret(q_r.ret_id), .q_cnt(q_cnt), .q_par(q_par),
          .prev_ret(c_ret[g-1]), .prev_cnt(c_cnt[g-1]), .prev_par(c_par[g-1]),
          .prev_id(c_id[g-1]),
          .ent_ret(c_ret[g]), .ent_cnt(c_cnt[g]), .ent_par(c_par[g]),
          .ent_id(c_id[g]), .hit(c_hit[g]), .hit_id(c_hit_id[g])
        );
      end
    end
  endgenerate

  // stored signatures are distinct, so at most one cell hits
  always_comb begin
    found_id = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found_id = found_id | c_hit_id[i];
    end
    found = |c_hit;
  end

  assign exhausted = (next_id_r == '1);
  assign can_store = (fill_r < FILL_W'(ENTRIES)) && (q_cnt <= CNT_W'(MAX_PARAMS));
  assign do_store  = res_go && !found && can_store;
  assign res_id    = found ? found_id : next_id_r;
  assign id_wide   = {{FIELD_W{1'b0}}, res_id};
  assign cfg_wide  = {{ID_BITS{1'b0}}, cfg_data};
  assign cfg_id    = cfg_wide[ID_BITS-1:0];

  always_comb begin
    st_nxt        = st_r;
    fill_nxt      = fill_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_CMP;
      end
      ST_CMP: begin
        st_nxt = ST_RES;
      end
      ST_RES: begin
        if (res_go) begin
          st_nxt                    = in_acc ? ST_CMP : ST_IDLE;
          out_valid_nxt             = 1'b1;
          out_data_nxt.type_id      = id_wide[FIELD_W-1:0];
          out_data_nxt.emit_decl    = !found;
          out_data_nxt.not_stored   = !found && !can_store;
          out_data_nxt.id_exhausted = !found && exhausted;
          if (!found && !exhausted) next_id_nxt = next_id_r + ID_BITS'(1);
          if (do_store) fill_nxt = fill_r + FILL_W'(1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_acc) begin
      fill_nxt    = '0;
      next_id_nxt = (cfg_id == '0) ? ID_BITS'(1) : cfg_id;
    end
  end

  // entry points carry no parameters
  always_comb begin
    q_nxt = in_data;
    if (in_data.is_entry) q_nxt.param_count = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fill_r      <= '0;
      next_id_r   <= ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      q_r <= q_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SDT_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_r <= FILL_W'(ENTRIES))
  `SDT_ASSERT_IMPLIES(a_single_hit, st_r == ST_RES, $onehot0(c_hit))
  `SDT_ASSERT_NEXT(a_store_fill, do_store && !cfg_acc, fill_r == $past(fill_r) + FILL_W'(1))
  `SDT_ASSERT_NEXT(a_accept_cmp, in_acc, st_r == ST_CMP)

endmodule
`default_nettype wire

// ===== verif/tb_signature_dedup_table_top.sv =====
// Testbench, signature dedup table: scripted and random requests, checked by script or predictor.
`timescale 1ns / 1ps
module tb_signature_dedup_table_top;
  import sdt_pkg::*;

  localparam int FMAX = (1 << FIELD_W) - 1;
  localparam logic [FIELD_W-1:0] ID_TOP = '1;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 6;
  localparam int RANDOM_REQS = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sdt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sdt_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;

  // expectation that travels with the request currently driven
  logic req_typed = 1'b0;
  sdt_out_t req_want = '0;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_starts = 0;
  int n_hits = 0;
  int n_unstored = 0;
  int n_saturated = 0;

  signature_dedup_table_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  logic [FIELD_W-1:0] sig_ret [ENTRIES_C];
  logic [CNT_W-1:0]   sig_cnt [ENTRIES_C];
  logic [FIELD_W-1:0] sig_par [ENTRIES_C][MAX_PARAMS_C];
  logic [FIELD_W-1:0] sig_id  [ENTRIES_C];
  int                 sig_fill;
  logic [FIELD_W-1:0] next_id;
  sdt_out_t           awaited_lookups[$];

  function automatic logic [FIELD_W-1:0] param_at(sdt_in_t r, int k);
    return r[(MAX_PARAMS_C-1-k)*FIELD_W +: FIELD_W];
  endfunction

  function automatic sdt_in_t with_param(sdt_in_t r, int k, logic [FIELD_W-1:0] v);
    r[(MAX_PARAMS_C-1-k)*FIELD_W +: FIELD_W] = v;
    return r;
  endfunction

  function automatic void restart_ids(logic [FIELD_W-1:0] v);
    next_id = (v == '0) ? FIELD_W'(1) : v;
    sig_fill = 0;
  endfunction

  function automatic sdt_out_t intern_signature(sdt_in_t r);
    sdt_out_t res;
    logic [CNT_W-1:0] cnt;
    bit hit;
    bit same;
    res = '0;
    hit = 1'b0;
    cnt = r.is_entry ? '0 : r.param_count;
    if (cnt <= MAX_PARAMS_C) begin
      for (int i = 0; i < sig_fill; i++) begin
        if (!hit && sig_ret[i] == r.ret_id && sig_cnt[i] == cnt) begin
          same = 1'b1;
          for (int j = 0; j < cnt; j++)
            if (sig_par[i][j] != param_at(r, j)) same = 1'b0;
          if (same) begin
            hit = 1'b1;
            res.type_id = sig_id[i];
          end
        end
      end
    end
    if (!hit) begin
      res.emit_decl = 1'b1;
      res.type_id = next_id;
      if (next_id == ID_TOP) res.id_exhausted = 1'b1;
      else next_id = next_id + 1'b1;
      if (sig_fill < ENTRIES_C && cnt <= MAX_PARAMS_C) begin
        sig_ret[sig_fill] = r.ret_id;
        sig_cnt[sig_fill] = cnt;
        sig_id[sig_fill] = res.type_id;
        for (int j = 0; j < cnt; j++) sig_par[sig_fill][j] = param_at(r, j);
        sig_fill++;
      end else begin
        res.not_stored = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin : scoreboard
    sdt_out_t pred;
    sdt_out_t want;
    if (!rst_n) begin
      restart_ids(FIELD_W'(1));
    end else begin
      if (cfg_valid && cfg_ready) begin
        restart_ids(cfg_data);
        n_starts++;
      end
      if (in_valid && !in_stall) begin
        pred = intern_signature(in_data);
        if (!pred.emit_decl) n_hits++;
        if (pred.not_stored) n_unstored++;
        if (pred.id_exhausted) n_saturated++;
        awaited_lookups.push_back(req_typed ? req_want : pred);
      end
      if (out_valid && !out_stall) begin
        if (awaited_lookups.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got %p", $time, out_data);
        end else begin
          want = awaited_lookups.pop_front();
          n_checked++;
          if (out_data.type_id !== want.type_id)
            report_field("type_id", want.type_id, out_data.type_id);
          if (out_data.emit_decl !== want.emit_decl)
            report_field("emit_decl", want.emit_decl, out_data.emit_decl);
          if (out_data.not_stored !== want.not_stored)
            report_field("not_stored", want.not_stored, out_data.not_stored);
          if (out_data.id_exhausted !== want.id_exhausted)
            report_field("id_exhausted", want.id_exhausted, out_data.id_exhausted);
        end
      end
    end
  end

  // ------------------------------------------------------------ result side
  initial begin : result_sink
    int n;
    forever begin
      n = stalls_on ? $urandom_range(0, 18) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ------------------------------------------------------------ request side
  typedef struct {
    bit                 is_cfg;
    logic [FIELD_W-1:0] start_val;
    sdt_in_t            req;
    bit                 typed;
    sdt_out_t           want;
  } script_row_t;

  script_row_t script[$];
  sdt_in_t recent[$];

  function automatic sdt_in_t sig(logic entry, int ret, int cnt, int pfill);
    sdt_in_t r;
    r.is_entry = entry;
    r.ret_id = FIELD_W'(ret);
    r.param_count = CNT_W'(cnt);
    for (int j = 0; j < MAX_PARAMS_C; j++) r = with_param(r, j, FIELD_W'(pfill));
    return r;
  endfunction

  function automatic sdt_out_t outcome(int id, logic e, logic n, logic x);
    sdt_out_t o;
    o.type_id = FIELD_W'(id);
    o.emit_decl = e;
    o.not_stored = n;
    o.id_exhausted = x;
    return o;
  endfunction

  function automatic void add_req(sdt_in_t r, bit typed, sdt_out_t w);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.start_val = '0;
    row.req = r;
    row.typed = typed;
    row.want = w;
    script.push_back(row);
  endfunction

  function automatic void add_start(int v);
    script_row_t row;
    row.is_cfg = 1'b1;
    row.start_val = FIELD_W'(v);
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic sdt_in_t random_sig();
    sdt_in_t r;
    r.is_entry = 1'($urandom_range(0, 1));
    r.ret_id = FIELD_W'($urandom_range(0, FMAX));
    r.param_count = CNT_W'($urandom_range(0, 15));
    for (int j = 0; j < MAX_PARAMS_C; j++)
      r = with_param(r, j, FIELD_W'($urandom_range(0, FMAX)));
    return r;
  endfunction

  function automatic sdt_in_t draw_signature(bit fresh_only);
    sdt_in_t s;
    int kind;
    int k;
    int j;
    kind = fresh_only ? 0 : $urandom_range(0, 99);
    if (kind >= 35 && kind < 80 && recent.size() == 0) kind = 0;
    s = random_sig();
    if (kind < 35) begin
      s.is_entry = ($urandom_range(0, 7) == 0);
      s.param_count = CNT_W'($urandom_range(0, MAX_PARAMS_C));
      case ($urandom_range(0, 3))
        0: s.ret_id = '0;
        1: s.ret_id = ID_TOP;
        2: s.ret_id = FIELD_W'($urandom_range(1, 4));
        default: ;
      endcase
    end else if (kind < 65) begin
      s = recent[$urandom_range(0, recent.size() - 1)];
      k = s.is_entry ? 0 : s.param_count;
      for (j = k; j < MAX_PARAMS_C; j++)
        s = with_param(s, j, FIELD_W'($urandom_range(0, FMAX)));
      if (k == 0 && $urandom_range(0, 1)) begin
        s.is_entry = 1'b1;
        s.param_count = CNT_W'($urandom_range(0, 15));
      end
    end else if (kind < 80) begin
      s = recent[$urandom_range(0, recent.size() - 1)];
      k = s.is_entry ? 0 : s.param_count;
      case ($urandom_range(0, 2))
        0: s.ret_id = s.ret_id ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
        1: begin
          if (k > 0) begin
            j = $urandom_range(0, k - 1);
            s = with_param(s, j,
                           param_at(s, j) ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1)));
          end else begin
            s.ret_id = s.ret_id ^ FIELD_W'(1);
          end
        end
        default: begin
          s.is_entry = 1'b0;
          s.param_count = (k == MAX_PARAMS_C) ? CNT_W'(k - 1) : CNT_W'(k + 1);
        end
      endcase
    end else if (kind < 90) begin
      s.is_entry = 1'b0;
      s.param_count = CNT_W'($urandom_range(MAX_PARAMS_C + 1, 15));
    end
    if (s.is_entry || s.param_count <= MAX_PARAMS_C) begin
      recent.push_back(s);
      if (recent.size() > 48) void'(recent.pop_front());
    end
    return s;
  endfunction

  task automatic send_req(sdt_in_t r, bit typed, sdt_out_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    req_typed <= typed;
    req_want <= w;
    n_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_id(logic [FIELD_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    recent.delete();
  endtask

  initial begin : stimulus
    int n_script;
    int done;
    int phase;
    int len;
    int sv;
    sdt_in_t s;

    // reset state: ids start at 1
    add_req(sig(0, 0, 0, 0), 1, outcome(1, 1, 0, 0));
    add_req(sig(0, 0, 0, 0), 1, outcome(1, 0, 0, 0));
    add_req(sig(1, 0, 8, FMAX), 1, outcome(1, 0, 0, 0));        // entry point: count forced to 0
    add_req(sig(0, FMAX, 8, FMAX), 1, outcome(2, 1, 0, 0));
    add_req(sig(0, FMAX, 8, FMAX), 1, outcome(2, 0, 0, 0));
    add_req(with_param(sig(0, FMAX, 8, FMAX), 7, 0), 1, outcome(3, 1, 0, 0));
    add_req(sig(0, 0, 9, 0), 1, outcome(4, 1, 1, 0));           // too many parameters
    add_req(sig(0, 0, 9, 0), 1, outcome(5, 1, 1, 0));
    add_req(sig(0, 0, 15, FMAX), 1, outcome(6, 1, 1, 0));
    add_req(sig(1, 0, 15, FMAX), 1, outcome(1, 0, 0, 0));
    add_req(with_param(with_param(sig(0, 5, 2, 0), 0, 7), 1, 9), 1, outcome(7, 1, 0, 0));
    add_req(with_param(with_param(sig(0, 5, 2, FMAX), 0, 7), 1, 9), 1, outcome(7, 0, 0, 0));
    add_req(with_param(sig(0, 5, 1, 0), 0, 7), 1, outcome(8, 1, 0, 0));
    s = random_sig();
    s.is_entry = 1'b0;
    s.param_count = 4;
    add_req(s, 0, '0);
    add_req(with_param(s, 6, ~param_at(s, 6)), 0, '0);
    add_start(0);                                               // zero loads one
    add_req(sig(0, FMAX, 8, FMAX), 1, outcome(1, 1, 0, 0));
    add_start(FMAX - 1);                                        // counter saturation
    add_req(sig(0, 1, 0, 0), 1, outcome(FMAX - 1, 1, 0, 0));
    add_req(sig(0, 2, 0, 0), 1, outcome(FMAX, 1, 0, 1));
    add_req(sig(0, 3, 0, 0), 1, outcome(FMAX, 1, 0, 1));
    add_req(sig(0, 2, 0, 0), 1, outcome(FMAX, 0, 0, 0));
    add_req(sig(0, 1, 0, 0), 1, outcome(FMAX - 1, 0, 0, 0));
    add_req(sig(0, 9, 10, 3), 1, outcome(FMAX, 1, 1, 1));
    add_start(FMAX);
    add_req(sig(0, 0, 0, 0), 1, outcome(FMAX, 1, 0, 1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) write_start_id(script[i].start_val);
      else send_req(script[i].req, script[i].typed, script[i].want);
    end
    n_script = n_sent;

    done = 0;
    phase = 0;
    while (done < RANDOM_REQS) begin
      case ($urandom_range(0, 5))
        0: sv = 0;
        1: sv = 1;
        2: sv = FMAX;
        3: sv = FMAX - $urandom_range(0, 40);
        default: sv = $urandom_range(0, FMAX);
      endcase
      if (phase == 0) sv = 1;
      write_start_id(FIELD_W'(sv));
      len = $urandom_range(40, 110);
      for (int n = 0; n < len; n++) begin
        if (n % 25 == 0) begin
          gaps_on = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
        // first phase starts with enough new signatures to fill the table
        s = draw_signature(phase == 0 && n < ENTRIES_C + 4);
        send_req(s, 0, '0);
        done++;
      end
      phase++;
    end

    wait_drained();
    $display("%0d requests (%0d scripted), %0d start-id writes, %0d results checked",
             n_sent, n_script, n_starts, n_checked);
    $display("%0d hits, %0d not stored, %0d with the id counter saturated",
             n_hits, n_unstored, n_saturated);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sdt_pkg.sv
rtl/sdt_cell.sv
rtl/signature_dedup_table_top.sv
verif/tb_signature_dedup_table_top.sv
